[hdl/alf_pkg.sv]
// ----------------------------------------------------------------------------
// alf_pkg
// Shared types and constants of the audio level LED fader: register indexes,
// reset values, the controller state type and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package alf_pkg;

    // Fixed field widths.
    localparam int DEV_W      = 10;   // sample, DC level and deviation width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int FADE_W     = 6;    // fade limit register width
    localparam int STEP_W     = 6;    // fade step counter width
    localparam int PWM_W      = 8;
    localparam int IN_TDATA_W = 16;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FADE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FADE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_PRESET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CAL  = 3'd5;

    // Reset values.
    localparam logic [FADE_W-1:0] UP_FADE_RST   = 6'd8;
    localparam logic [FADE_W-1:0] DOWN_FADE_RST = 6'd8;
    localparam logic [DEV_W-1:0]  MIN_START_RST = 10'd255;
    localparam logic [DEV_W-1:0]  MAX_START_RST = 10'd0;
    localparam logic [DEV_W-1:0]  DC_PRESET_RST = 10'd0;

    // Most fade steps per sample, and the offset taken off the raw quotient.
    localparam logic [FADE_W-1:0] FADE_CAP = 6'd32;
    localparam int TARGET_OFFSET = 21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DC_LOAD,
        ST_DEV,
        ST_TGT_START,
        ST_TGT_WAIT,
        ST_FADE
    } t_state;

    typedef struct packed {
        logic load_sample;    // take the sample, run calibration bookkeeping
        logic dc_load;        // take the average as DC level
        logic dev_update;     // deviation and running min/max
        logic tgt_div_start;  // start the target division
        logic tgt_zero;       // target is zero (flat range)
        logic tgt_load;       // take the target from the quotient
        logic fade_step;      // one fade step
    } t_cmd;

    typedef struct packed {
        logic calibrated;
        logic cal_last;       // the next sample completes calibration
        logic span_zero;      // running max equals running min
        logic div_busy;
        logic div_done;
        logic fade_more;      // fade level still too far from target
        logic step_emits;     // the next step produces a result
        logic step_final;     // the next step ends the run
        logic out_free;       // output register can take a result
    } t_status;

endpackage

`default_nettype wire

[hdl/audio_level_led_fader_core.sv]
// ----------------------------------------------------------------------------
// audio_level_led_fader_core
// Microphone samples in, runs of LED PWM levels out, with DC calibration,
// range tracking and rate-limited fading.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Content
//  s_axis    in         s_axis_tvalid/tready       sample
//  m_axis    out        m_axis_tvalid/tready       pwm_level, last_of_run (tlast)
//  cfg       in         i_cfg_valid/o_cfg_ready    register index and data
//
// One sample is worked on at a time. A calibration sample only runs the
// calibration bookkeeping. A calibrated sample passes through deviation,
// range update and, unless the range is flat, the bit-serial target division
// (NUM_W is 19 at the default settings), then through up to 32 fade steps or
// none when no step is due; the sample that ends calibration first takes the
// DC average, which is a reciprocal multiplication.
// Reset is synchronous and active low and needs no clearing pass. A stalled
// output holds the fade sequencer only on steps that produce a result.
`default_nettype none

module audio_level_led_fader_core #(
    parameter int SAMPLE_BITS     = 10,
    parameter int LEVELS          = 256,
    parameter int FADE_GAP        = 2,
    parameter int WAKEUP_SAMPLES  = 16,
    parameter int AVERAGE_SAMPLES = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [alf_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [9:0] sample
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [alf_pkg::PWM_W-1:0]      m_axis_tdata,   // [7:0] pwm_level
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [alf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [alf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import alf_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    assign o_cfg_ready = 1'b1;

    alf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    alf_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .LEVELS          (LEVELS),
        .FADE_GAP        (FADE_GAP),
        .WAKEUP_SAMPLES  (WAKEUP_SAMPLES),
        .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample      (s_axis_tdata[DEV_W-1:0]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_pwm_level   (m_axis_tdata),
        .o_last_of_run (m_axis_tlast)
    );

    // The divider is started only when it is free.
    a_div_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.tgt_div_start |-> !w_sts.div_busy)
        else $error("divider started while busy");

    // A step is taken only while the level is outside the gap.
    a_step_needed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fade_step |-> w_sts.fade_more)
        else $error("fade step taken inside the gap");

    // A step that produces a result never overwrites an untaken one.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.fade_step && w_sts.step_emits) |-> w_sts.out_free)
        else $error("result overwritten in output register");

    // No new sample is taken while a division is still running.
    a_idle_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.div_busy)
        else $error("input ready while divider busy");

endmodule

`default_nettype wire

[hdl/alf_div.sv]
// ----------------------------------------------------------------------------
// alf_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             trial_ge;
    logic [DEN_W-1:0] n_rem;

    // The remainder stays below the divisor, so the shifted trial fits DEN_W+1 bits.
    always_comb begin
        trial     = {r_rem, r_num[NUM_W-1]};
        trial_sub = trial - {1'b0, r_den};
        trial_ge  = trial >= {1'b0, r_den};
        n_rem     = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], trial_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

[hdl/alf_dp.sv]
// ----------------------------------------------------------------------------
// alf_dp
// Datapath: configuration registers, calibration, deviation tracking, target
// computation through the divider, fade stepping and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_dp #(
    parameter int SAMPLE_BITS     = 10,
    parameter int LEVELS          = 256,
    parameter int FADE_GAP        = 2,
    parameter int WAKEUP_SAMPLES  = 16,
    parameter int AVERAGE_SAMPLES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire alf_pkg::t_cmd                 i_cmd,
    output alf_pkg::t_status                   o_sts,
    input  wire logic [alf_pkg::DEV_W-1:0]     i_sample,
    input  wire logic                          i_cfg_we,
    input  wire logic [alf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [alf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [alf_pkg::PWM_W-1:0]     o_pwm_level,
    output logic                               o_last_of_run
);

    import alf_pkg::*;

    localparam int SW      = (SAMPLE_BITS < DEV_W) ? SAMPLE_BITS : DEV_W;
    localparam int SUM_W   = SW + $clog2(AVERAGE_SAMPLES + 1);
    localparam int CNT_W   = $clog2(WAKEUP_SAMPLES + AVERAGE_SAMPLES + 1);
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int PROD_W  = DEV_W + LVL_W;
    localparam int NUM_W   = PROD_W;
    localparam int DEN_W   = DEV_W;
    localparam int FW      = $clog2(LEVELS);
    localparam int HALF_GAP = FADE_GAP / 2;

    // Floor average by reciprocal multiplication. With the shift at the sum
    // width plus the divisor's ceiling log2 the product is exact for every sum.
    localparam int     AVG_SH = $clog2(AVERAGE_SAMPLES);
    localparam int     DC_SH  = SUM_W + AVG_SH;
    localparam int     RCP_W  = SUM_W + 2;
    localparam int     DCP_W  = SUM_W + RCP_W;
    localparam longint DC_RCP = ((longint'(1) << DC_SH) + longint'(AVERAGE_SAMPLES) - 1)
                                / longint'(AVERAGE_SAMPLES);

    // Configuration and persistent state.
    logic [FADE_W-1:0] r_up_fade;
    logic [FADE_W-1:0] r_down_fade;
    logic [DEV_W-1:0]  r_dc_preset;
    logic              r_calibrated;
    logic [CNT_W-1:0]  r_cal_count;
    logic [SUM_W-1:0]  r_dc_sum;
    logic [DEV_W-1:0]  r_dc_level;
    logic [DEV_W-1:0]  r_dev_min;
    logic [DEV_W-1:0]  r_dev_max;
    logic [FW-1:0]     r_fade;
    logic [STEP_W-1:0] r_steps;
    logic              r_out_valid;

    // Per-sample payload.
    logic [DEV_W-1:0]  r_sample;
    logic [DEV_W-1:0]  r_dev;
    logic [FW-1:0]     r_target;
    logic [PWM_W-1:0]  r_pwm;
    logic              r_last;

    logic [DEV_W-1:0]  s_masked;
    logic [DCP_W-1:0]  dc_prod;
    logic [DEV_W-1:0]  dc_avg;
    logic [DEV_W-1:0]  n_dev;
    logic [DEV_W-1:0]  dev_off;
    logic [DEV_W-1:0]  dev_span;
    logic [NUM_W-1:0]  prod;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_busy;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [LVL_W-1:0]  quot_q;
    logic [LVL_W-1:0]  quot_off;
    logic [FW-1:0]     n_target;

    logic              dir_down;
    logic [FW-1:0]     gap;
    logic [FW-1:0]     n_fade;
    logic [FADE_W-1:0] limit_raw;
    logic [FADE_W-1:0] limit;
    logic [STEP_W-1:0] step_cnt;
    logic [STEP_W:0]   step_after;
    logic              fade_more;
    logic              step_emits;
    logic              more_after;
    logic              gap_closes;

    assign s_masked = DEV_W'(i_sample[SW-1:0]);

    // Deviation and target arithmetic.
    always_comb begin
        dc_prod  = DCP_W'(r_dc_sum) * DCP_W'(DC_RCP);
        dc_avg   = dc_prod[DC_SH +: DEV_W];
        n_dev    = (r_sample >= r_dc_level) ? (r_sample - r_dc_level)
                                            : (r_dc_level - r_sample);
        dev_off  = r_dev - r_dev_min;
        dev_span = r_dev_max - r_dev_min;
        prod     = NUM_W'(dev_off) * NUM_W'(LEVELS);
        div_start = i_cmd.tgt_div_start;
        div_num  = prod;
        div_den  = dev_span;
        quot_q   = div_quot[LVL_W-1:0];
        quot_off = quot_q - LVL_W'(TARGET_OFFSET);
        if (quot_q <= LVL_W'(TARGET_OFFSET)) begin
            n_target = '0;
        end else if (quot_off > LVL_W'(LEVELS - 1)) begin
            n_target = FW'(LEVELS - 1);
        end else begin
            n_target = FW'(quot_off);
        end
    end

    // Fade step. The direction and limit stay fixed over one run, since the
    // level never crosses the target.
    always_comb begin
        dir_down   = r_fade > r_target;
        gap        = dir_down ? (r_fade - r_target) : (r_target - r_fade);
        n_fade     = dir_down ? (r_fade - 1'b1) : (r_fade + 1'b1);
        limit_raw  = dir_down ? r_down_fade : r_up_fade;
        limit      = (limit_raw > FADE_CAP) ? FADE_CAP : limit_raw;
        step_cnt   = r_steps + 1'b1;
        step_after = {1'b0, step_cnt} + 1'b1;
        fade_more  = gap > FW'(HALF_GAP);
        step_emits = step_cnt < limit;
        gap_closes = (gap - 1'b1) <= FW'(HALF_GAP);
        more_after = (step_after < {1'b0, limit}) && !gap_closes;
    end

    alf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_fade    <= UP_FADE_RST;
            r_down_fade  <= DOWN_FADE_RST;
            r_dc_preset  <= DC_PRESET_RST;
            r_calibrated <= 1'b0;
            r_cal_count  <= '0;
            r_dc_sum     <= '0;
            r_dc_level   <= '0;
            r_dev_min    <= MIN_START_RST;
            r_dev_max    <= MAX_START_RST;
            r_fade       <= '0;
            r_steps      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_sample && !r_calibrated) begin
                if (r_cal_count >= CNT_W'(WAKEUP_SAMPLES)) begin
                    r_dc_sum <= r_dc_sum + SUM_W'(s_masked);
                end
                r_cal_count <= r_cal_count + 1'b1;
            end
            if (i_cmd.dc_load) begin
                r_dc_level   <= dc_avg;
                r_calibrated <= 1'b1;
            end
            if (i_cmd.dev_update) begin
                if (n_dev < r_dev_min) begin
                    r_dev_min <= n_dev;
                end
                if (n_dev > r_dev_max) begin
                    r_dev_max <= n_dev;
                end
            end
            if (i_cmd.tgt_zero || i_cmd.tgt_load) begin
                r_steps <= '0;
            end
            if (i_cmd.fade_step) begin
                r_fade  <= n_fade;
                r_steps <= step_cnt;
            end
            if (i_cmd.fade_step && step_emits) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Writes are to arrive only while the block is idle; the block does not enforce it.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_UP_FADE:   r_up_fade   <= i_cfg_data[FADE_W-1:0];
                    CFG_DOWN_FADE: r_down_fade <= i_cfg_data[FADE_W-1:0];
                    CFG_MIN_START: r_dev_min   <= i_cfg_data[DEV_W-1:0];
                    CFG_MAX_START: r_dev_max   <= i_cfg_data[DEV_W-1:0];
                    CFG_DC_PRESET: begin
                        r_dc_preset <= i_cfg_data[DEV_W-1:0];
                        r_dc_level  <= i_cfg_data[DEV_W-1:0];
                    end
                    CFG_SKIP_CAL: begin
                        if (i_cfg_data[0]) begin
                            r_calibrated <= 1'b1;
                            r_dc_level   <= r_dc_preset;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= s_masked;
        end
        if (i_cmd.dev_update) begin
            r_dev <= n_dev;
        end
        if (i_cmd.tgt_zero) begin
            r_target <= '0;
        end else if (i_cmd.tgt_load) begin
            r_target <= n_target;
        end
        if (i_cmd.fade_step && step_emits) begin
            r_pwm  <= PWM_W'(n_fade);
            r_last <= !more_after;
        end
    end

    // The run ends with a step that hits the limit or closes the gap; a step
    // that emits its last result may still be followed by the limit step.
    always_comb begin
        o_sts.calibrated = r_calibrated;
        o_sts.cal_last   = r_cal_count == CNT_W'(WAKEUP_SAMPLES + AVERAGE_SAMPLES - 1);
        o_sts.span_zero  = r_dev_max == r_dev_min;
        o_sts.div_busy   = div_busy;
        o_sts.div_done   = div_done;
        o_sts.fade_more  = fade_more;
        o_sts.step_emits = step_emits;
        o_sts.step_final = !step_emits || gap_closes;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pwm_level   = r_pwm;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

[hdl/alf_ctrl.sv]
// ----------------------------------------------------------------------------
// alf_ctrl
// Controller: sequences calibration, target division and fade stepping for
// one sample at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire alf_pkg::t_status i_sts,
    output alf_pkg::t_cmd         o_cmd
);

    import alf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   step_ok;

    // A step that emits needs room in the output register.
    assign step_ok = i_sts.fade_more && (!i_sts.step_emits || i_sts.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.calibrated) begin
                        n_state = ST_DEV;
                    end else if (i_sts.cal_last) begin
                        n_state = ST_DC_LOAD;
                    end
                end
            end
            ST_DC_LOAD: n_state = ST_DEV;
            ST_DEV: n_state = ST_TGT_START;
            ST_TGT_START: n_state = i_sts.span_zero ? ST_FADE : ST_TGT_WAIT;
            ST_TGT_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_FADE;
                end
            end
            ST_FADE: begin
                if (!i_sts.fade_more || (step_ok && i_sts.step_final)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid;
            end
            ST_DC_LOAD:   o_cmd.dc_load      = 1'b1;
            ST_DEV:       o_cmd.dev_update   = 1'b1;
            ST_TGT_START: begin
                o_cmd.tgt_zero      = i_sts.span_zero;
                o_cmd.tgt_div_start = !i_sts.span_zero;
            end
            ST_TGT_WAIT:  o_cmd.tgt_load     = i_sts.div_done;
            ST_FADE:      o_cmd.fade_step    = step_ok;
            default: ;
        endcase
    end

endmodule

`default_nettype wire
